FILE: design/at_ipd_frame_extractor_defines.svh
// assertion macros for the frame extractor
`ifndef AT_IPD_FRAME_EXTRACTOR_DEFINES_SVH
`define AT_IPD_FRAME_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH

`define IPDFX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipdfx check failed");

`define IPDFX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipdfx check failed");

`else

`define IPDFX_ASSERT_NOW(label, clk, rst, ante, cons)

`define IPDFX_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/ipdfx_pkg.sv
package ipdfx_pkg;

  typedef enum logic [1:0] {
    MODE_SCAN = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_COPY = 2'd2
  } mode_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_CLOSED  = 1'b1;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [2:0] HDR_LEN   = 3'd5;
  localparam logic [2:0] CLOSE_LEN = 3'd6;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h2B;
      3'd1: ch = 8'h49;
      3'd2: ch = 8'h50;
      3'd3: ch = 8'h44;
      3'd4: ch = 8'h2C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h43;
      3'd1: ch = 8'h4C;
      3'd2: ch = 8'h4F;
      3'd3: ch = 8'h53;
      3'd4: ch = 8'h45;
      3'd5: ch = 8'h44;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: design/ipdfx_in_if.sv
interface ipdfx_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

FILE: design/ipdfx_out_if.sv
interface ipdfx_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       frame_last;

  modport source (output valid, output kind, output payload_byte, output frame_last,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_last,
                output ready);
endinterface

FILE: design/at_ipd_frame_extractor.sv
// channel   | dir | word
// ----------+-----+-----------------------------------------
// rx_in     | in  | cmd, rx_byte
// res_out   | out | kind, payload_byte, frame_last
//
// one word is taken per cycle while rx_in is not stalled; its result, if any, shows on res_out the next cycle
// parser state and the output register update in the cycle a word is taken
// rst is synchronous and clears all parser state and the output valid
// rx_in stalls only while a result sits in the output register and res_out is not ready
`include "at_ipd_frame_extractor_defines.svh"

module at_ipd_frame_extractor #(
  parameter int LINE_CAPACITY = 63
) (
  input logic         clk,
  input logic         rst,
  ipdfx_in_if.sink    rx_in,
  ipdfx_out_if.source res_out
);
  import ipdfx_pkg::*;

  localparam int LCW = $clog2(LINE_CAPACITY + 1);

  mode_t            mode, mode_next;
  logic [2:0]       prefix_pos, prefix_pos_next;
  logic [15:0]      length_acc, length_acc_next;
  logic [15:0]      bytes_left, bytes_left_next;
  logic [LCW-1:0]   line_count, line_count_next;
  logic             line_matches, line_matches_next;
  logic             line_overflow, line_overflow_next;
  logic             prev_was_cr, prev_was_cr_next;

  logic             out_valid;
  logic             out_kind;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             accept;
  logic [7:0]       c;
  logic             is_digit;
  logic [19:0]      len_mul;
  logic [15:0]      left_dec;
  logic             emit;
  logic             emit_kind;
  logic             emit_last;
  logic             hdr_done;
  logic             hit;

  assign rx_in.ready = !out_valid || res_out.ready;
  assign accept      = rx_in.valid && rx_in.ready;
  assign c           = rx_in.rx_byte;
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign len_mul     = {1'b0, length_acc, 3'b000} + {3'b000, length_acc, 1'b0}
                       + {16'd0, c[3:0]};
  assign left_dec    = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;

  // next state
  always_comb begin
    mode_next          = mode;
    prefix_pos_next    = prefix_pos;
    length_acc_next    = length_acc;
    bytes_left_next    = bytes_left;
    line_count_next    = line_count;
    line_matches_next  = line_matches;
    line_overflow_next = line_overflow;
    prev_was_cr_next   = prev_was_cr;
    hdr_done           = 1'b0;
    if (rx_in.cmd == CMD_CLEAR) begin
      mode_next          = MODE_SCAN;
      prefix_pos_next    = 3'd0;
      length_acc_next    = 16'd0;
      bytes_left_next    = 16'd0;
      line_count_next    = '0;
      line_matches_next  = 1'b1;
      line_overflow_next = 1'b0;
      prev_was_cr_next   = 1'b0;
    end else begin
      case (mode)
        MODE_LEN: begin
          if (is_digit) begin
            length_acc_next = (len_mul[19:16] != 4'd0) ? LEN_MAX : len_mul[15:0];
          end else if (c == CH_COLON) begin
            bytes_left_next = length_acc;
            mode_next       = (length_acc != 16'd0) ? MODE_COPY : MODE_SCAN;
          end else begin
            mode_next         = MODE_SCAN;
            prefix_pos_next   = (c == CH_PLUS) ? 3'd1 : 3'd0;
            line_count_next   = '0;
            line_matches_next = 1'b1;
          end
        end
        MODE_COPY: begin
          bytes_left_next = left_dec;
          if (left_dec == 16'd0) begin
            mode_next = MODE_SCAN;
          end
        end
        default: begin
          mode_next = MODE_SCAN;
          if (prefix_pos < HDR_LEN && c == hdr_char(prefix_pos)) begin
            prefix_pos_next = prefix_pos + 3'd1;
            if (prefix_pos + 3'd1 == HDR_LEN) begin
              hdr_done          = 1'b1;
              mode_next         = MODE_LEN;
              length_acc_next   = 16'd0;
              prefix_pos_next   = 3'd0;
              line_count_next   = '0;
              line_matches_next = 1'b1;
            end
          end else begin
            prefix_pos_next = (c == CH_PLUS) ? 3'd1 : 3'd0;
          end
          if (!hdr_done) begin
            if (c == CH_CR) begin
              prev_was_cr_next = 1'b1;
            end else if (c == CH_LF) begin
              line_count_next    = '0;
              line_matches_next  = 1'b1;
              line_overflow_next = 1'b0;
              prev_was_cr_next   = 1'b0;
            end else begin
              prev_was_cr_next = 1'b0;
              if (line_count < LCW'(LINE_CAPACITY)) begin
                if (line_count >= LCW'(CLOSE_LEN) || c != close_char(line_count[2:0])) begin
                  line_matches_next = 1'b0;
                end
                line_count_next = line_count + 1'b1;
              end else begin
                line_overflow_next = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_PAYLOAD;
    emit_last = 1'b0;
    hit       = prev_was_cr && !line_overflow && line_matches
                && line_count == LCW'(CLOSE_LEN);
    if (rx_in.cmd == CMD_BYTE) begin
      case (mode)
        MODE_LEN: begin
          emit = 1'b0;
        end
        MODE_COPY: begin
          emit      = 1'b1;
          emit_last = (left_dec == 16'd0);
        end
        default: begin
          if (!hdr_done && c == CH_LF && hit) begin
            emit      = 1'b1;
            emit_kind = KIND_CLOSED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SCAN;
      prefix_pos    <= 3'd0;
      length_acc    <= 16'd0;
      bytes_left    <= 16'd0;
      line_count    <= '0;
      line_matches  <= 1'b1;
      line_overflow <= 1'b0;
      prev_was_cr   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        prefix_pos    <= prefix_pos_next;
        length_acc    <= length_acc_next;
        bytes_left    <= bytes_left_next;
        line_count    <= line_count_next;
        line_matches  <= line_matches_next;
        line_overflow <= line_overflow_next;
        prev_was_cr   <= prev_was_cr_next;
        out_valid     <= emit;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= emit_kind;
      out_byte <= (emit_kind == KIND_PAYLOAD) ? c : 8'd0;
      out_last <= emit_last;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.kind         = out_kind;
  assign res_out.payload_byte = out_byte;
  assign res_out.frame_last   = out_last;

  `IPDFX_ASSERT_NOW(a_copy_has_bytes, clk, rst, mode == MODE_COPY, bytes_left != 16'd0)
  `IPDFX_ASSERT_NOW(a_line_in_cap, clk, rst, 1'b1, line_count <= LCW'(LINE_CAPACITY))
  `IPDFX_ASSERT_NEXT(a_last_ends_copy, clk, rst,
                     accept && rx_in.cmd == CMD_BYTE && mode == MODE_COPY && bytes_left == 16'd1,
                     mode == MODE_SCAN && out_valid && out_last)
  `IPDFX_ASSERT_NOW(a_notice_clean, clk, rst, out_valid && out_kind == KIND_CLOSED, out_byte == 8'd0 && !out_last)

endmodule
